// ===== rtl/core/u2c_pkg.sv =====
package u2c_pkg;

    localparam int IN_W        = 39;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam int YEAR_W  = 15;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    localparam int YEAR_LSB  = 0;
    localparam int MONTH_LSB = YEAR_LSB + YEAR_W;
    localparam int DAY_LSB   = MONTH_LSB + MONTH_W;
    localparam int HOUR_LSB  = DAY_LSB + DAY_W;
    localparam int MIN_LSB   = HOUR_LSB + HOUR_W;
    localparam int SEC_LSB   = MIN_LSB + MIN_W;
    localparam int FIELDS_W  = SEC_LSB + SEC_W;

    localparam int NUM_STAGES = 10;

    localparam logic signed [IN_W-1:0] SPAN_LOW  = -39'sd210866760000;
    localparam logic signed [IN_W-1:0] SPAN_HIGH = 39'sd253402300799;

    // 2440588 whole days: shifts the epoch so the day number is a plain quotient
    localparam logic [IN_W-1:0] DAY_OFS = 39'd210866803200;

    // Exact reciprocal multipliers: floor(n / d) == (n * MUL) >> SHIFT over the operand width
    localparam int          ZQ_SHIFT = 42;
    localparam logic [32:0] ZQ_MUL   = 33'(((64'd1 << ZQ_SHIFT) + 64'd674) / 64'd675);
    localparam logic [9:0]  ZQ_DIV   = 10'd675;

    localparam logic [24:0] A_K     = 25'd7468865;
    localparam int          A_SHIFT = 42;
    localparam logic [24:0] A_MUL   = 25'(((64'd1 << A_SHIFT) + 64'd146096) / 64'd146097);

    localparam int          HR_SHIFT = 29;
    localparam logic [17:0] HR_MUL   = 18'(((64'd1 << HR_SHIFT) + 64'd3599) / 64'd3600);
    localparam logic [11:0] HR_SECS  = 12'd3600;

    localparam int          MN_SHIFT = 18;
    localparam logic [12:0] MN_MUL   = 13'(((64'd1 << MN_SHIFT) + 64'd59) / 64'd60);
    localparam logic [5:0]  MN_SECS  = 6'd60;

    localparam int          C_SHIFT = 40;
    localparam logic [27:0] C_MUL   = 28'(((64'd1 << C_SHIFT) + 64'd7304) / 64'd7305);

    localparam logic [23:0] B_BASE   = 24'd1525;
    localparam logic [27:0] N4_SUB   = 28'd2442;
    localparam logic [10:0] D_MUL    = 11'd1461;
    localparam logic [4:0]  E_WRAP   = 5'd14;
    localparam logic [4:0]  E_ONE    = 5'd1;
    localparam logic [4:0]  E_YEAR   = 5'd13;
    localparam logic [3:0]  FEB      = 4'd2;
    localparam logic [YEAR_W-1:0] YEAR_LATE  = 15'd4716;
    localparam logic [YEAR_W-1:0] YEAR_EARLY = 15'd4715;

    // floor(x / 30.6001) for the day-of-year offset, by threshold compare
    function automatic logic [4:0] calc_e(input logic [8:0] x);
        logic [4:0] e;
        e = '0;
        for (int k = 1; k <= 16; k++) begin
            if (int'(x) >= (306001 * k + 9999) / 10000) begin
                e = 5'(k);
            end
        end
        return e;
    endfunction

    // floor(30.6001 * e)
    function automatic logic [8:0] calc_x_off(input logic [4:0] e);
        logic [8:0] r;
        r = '0;
        for (int k = 0; k <= 16; k++) begin
            if (e == 5'(k)) begin
                r = 9'((306001 * k) / 10000);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/unix_time_to_calendar.sv =====
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: unix_seconds[38:0], zero pad [39]
// m_*      out  m_tvalid/m_tready  m_tdata: year, month, day, hour, minute, second;
//                                  m_tuser: out_of_range
// Ten register stages, one item per cycle sustained while m_tready stays high.
// An item accepted on s_* passes through stages 1 to 10 in order and is presented on m_* from the stage-10 register.
// The datapath is a chain of constant-reciprocal multipliers, each followed by a register.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stalled output holds; earlier stages keep filling bubbles, so s_tready drops only
// when every stage holds an item.
module unix_time_to_calendar (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [u2c_pkg::IN_TDATA_W-1:0]   s_tdata,   // [38:0] unix_seconds
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [u2c_pkg::OUT_TDATA_W-1:0]  m_tdata,   // year, month, day, hour, minute, second
    output logic                             m_tuser    // out_of_range
);
    import u2c_pkg::*;

    logic [NUM_STAGES:1]   vld_reg;
    logic [NUM_STAGES:1]   vld_next;
    logic [NUM_STAGES+1:1] rdy;

    always_comb
    begin
        rdy[NUM_STAGES+1] = m_tready;
        for (int i = NUM_STAGES; i >= 1; i--)
        begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end

    assign vld_next = {vld_reg[NUM_STAGES-1:1], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 1; i <= NUM_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    assign s_tready = rdy[1];
    assign m_tvalid = vld_reg[NUM_STAGES];

    // stage 1: range check, shift to day-aligned seconds
    logic signed [IN_W-1:0] secs;
    logic [IN_W-1:0]        s1_u_reg, s1_u_next;
    logic                   s1_oor_reg, s1_oor_next;

    assign secs        = signed'(s_tdata[IN_W-1:0]);
    assign s1_oor_next = (secs < SPAN_LOW) || (secs > SPAN_HIGH);
    assign s1_u_next   = s_tdata[IN_W-1:0] + DAY_OFS;

    // stage 2: day number
    logic [64:0] prod_z;
    logic [22:0] s2_z_reg, s2_z_next;
    logic [9:0]  s2_vlo_reg, s2_vlo_next;
    logic [6:0]  s2_ulo_reg, s2_ulo_next;
    logic        s2_oor_reg;

    assign prod_z      = 65'(s1_u_reg[IN_W-1:7]) * 65'(ZQ_MUL);
    assign s2_z_next   = prod_z[64:ZQ_SHIFT];
    assign s2_vlo_next = s1_u_reg[16:7];
    assign s2_ulo_next = s1_u_reg[6:0];

    // stage 3: second of day, century term magnitude and sign
    logic [9:0]  zk_lo, rday;
    logic [24:0] z4;
    logic [22:0] s3_z_reg;
    logic [16:0] s3_sod_reg, s3_sod_next;
    logic [23:0] s3_mag_reg, s3_mag_next;
    logic        s3_neg_reg, s3_neg_next;
    logic        s3_oor_reg;

    always_comb
    begin
        zk_lo       = s2_z_reg[9:0] * ZQ_DIV;
        rday        = s2_vlo_reg - zk_lo;
        s3_sod_next = {rday, s2_ulo_reg};
        z4          = {s2_z_reg, 2'b00};
        s3_neg_next = z4 < A_K;
        s3_mag_next = s3_neg_next ? 24'(A_K - z4) : 24'(z4 - A_K);
    end

    // stage 4: century quotient, hour
    logic [48:0] prod_a;
    logic [34:0] prod_h;
    logic [22:0] s4_z_reg;
    logic [6:0]  s4_q_reg, s4_q_next;
    logic [4:0]  s4_h_reg, s4_h_next;
    logic [16:0] s4_sod_reg;
    logic        s4_neg_reg;
    logic        s4_oor_reg;

    assign prod_a    = 49'(s3_mag_reg) * 49'(A_MUL);
    assign s4_q_next = prod_a[48:A_SHIFT];
    assign prod_h    = 35'(s3_sod_reg) * 35'(HR_MUL);
    assign s4_h_next = prod_h[HR_SHIFT+4:HR_SHIFT];

    // stage 5: B, seconds within the hour
    logic [6:0]  w;
    logic [23:0] bsum, bfull;
    logic [11:0] hk_lo;
    logic [22:0] s5_b_reg, s5_b_next;
    logic [11:0] s5_remh_reg, s5_remh_next;
    logic [4:0]  s5_h_reg;
    logic        s5_oor_reg;

    always_comb
    begin
        w            = s4_q_reg - (s4_q_reg >> 2);
        bsum         = {1'b0, s4_z_reg} + B_BASE;
        bfull        = s4_neg_reg ? (bsum - 24'(w)) : (bsum + 24'(w));
        s5_b_next    = bfull[22:0];
        hk_lo        = 12'(s4_h_reg) * HR_SECS;
        s5_remh_next = s4_sod_reg[11:0] - hk_lo;
    end

    // stage 6: year numerator, minute
    logic [27:0] n4full;
    logic [24:0] prod_m;
    logic [26:0] s6_n4_reg, s6_n4_next;
    logic [22:0] s6_b_reg;
    logic [11:0] s6_remh_reg;
    logic [4:0]  s6_h_reg;
    logic [5:0]  s6_m_reg, s6_m_next;
    logic        s6_oor_reg;

    assign n4full     = {1'b0, s5_b_reg, 4'b0000} + {3'b000, s5_b_reg, 2'b00} - N4_SUB;
    assign s6_n4_next = n4full[26:0];
    assign prod_m     = 25'(s5_remh_reg) * 25'(MN_MUL);
    assign s6_m_next  = prod_m[MN_SHIFT+5:MN_SHIFT];

    // stage 7: C, second
    logic [54:0] prod_c;
    logic [5:0]  mk_lo;
    logic [13:0] s7_c_reg, s7_c_next;
    logic [8:0]  s7_b_reg;
    logic [4:0]  s7_h_reg;
    logic [5:0]  s7_m_reg;
    logic [5:0]  s7_s_reg, s7_s_next;
    logic        s7_oor_reg;

    assign prod_c    = 55'(s6_n4_reg) * 55'(C_MUL);
    assign s7_c_next = prod_c[C_SHIFT+13:C_SHIFT];
    assign mk_lo     = s6_m_reg * MN_SECS;
    assign s7_s_next = s6_remh_reg[5:0] - mk_lo;

    // stage 8: day of the shifted year
    logic [10:0] dk;
    logic [8:0]  s8_x_reg, s8_x_next;
    logic [13:0] s8_c_reg;
    logic [4:0]  s8_h_reg;
    logic [5:0]  s8_m_reg;
    logic [5:0]  s8_s_reg;
    logic        s8_oor_reg;

    assign dk        = s7_c_reg[10:0] * D_MUL;
    assign s8_x_next = s7_b_reg - dk[10:2];

    // stage 9: month index
    logic [4:0]  s9_e_reg, s9_e_next;
    logic [8:0]  s9_x_reg;
    logic [13:0] s9_c_reg;
    logic [4:0]  s9_h_reg;
    logic [5:0]  s9_m_reg;
    logic [5:0]  s9_s_reg;
    logic        s9_oor_reg;

    assign s9_e_next = calc_e(s8_x_reg);

    // stage 10: output register
    logic [8:0]          dfull;
    logic [3:0]          mon;
    logic [YEAR_W-1:0]   o_year_reg, o_year_next;
    logic [MONTH_W-1:0]  o_month_reg, o_month_next;
    logic [DAY_W-1:0]    o_day_reg, o_day_next;
    logic [HOUR_W-1:0]   o_hour_reg, o_hour_next;
    logic [MIN_W-1:0]    o_min_reg, o_min_next;
    logic [SEC_W-1:0]    o_sec_reg, o_sec_next;
    logic                o_oor_reg;

    always_comb
    begin
        dfull = s9_x_reg - calc_x_off(s9_e_reg);
        mon   = (s9_e_reg < E_WRAP) ? 4'(s9_e_reg - E_ONE) : 4'(s9_e_reg - E_YEAR);
        if (s9_oor_reg)
        begin
            o_year_next  = '0;
            o_month_next = '0;
            o_day_next   = '0;
            o_hour_next  = '0;
            o_min_next   = '0;
            o_sec_next   = '0;
        end
        else
        begin
            o_year_next  = (mon > FEB) ? (YEAR_W'(s9_c_reg) - YEAR_LATE)
                                       : (YEAR_W'(s9_c_reg) - YEAR_EARLY);
            o_month_next = mon;
            o_day_next   = dfull[DAY_W-1:0];
            o_hour_next  = s9_h_reg;
            o_min_next   = s9_m_reg;
            o_sec_next   = s9_s_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s1_u_reg   <= s1_u_next;
            s1_oor_reg <= s1_oor_next;
        end
        if (rdy[2])
        begin
            s2_z_reg   <= s2_z_next;
            s2_vlo_reg <= s2_vlo_next;
            s2_ulo_reg <= s2_ulo_next;
            s2_oor_reg <= s1_oor_reg;
        end
        if (rdy[3])
        begin
            s3_z_reg   <= s2_z_reg;
            s3_sod_reg <= s3_sod_next;
            s3_mag_reg <= s3_mag_next;
            s3_neg_reg <= s3_neg_next;
            s3_oor_reg <= s2_oor_reg;
        end
        if (rdy[4])
        begin
            s4_z_reg   <= s3_z_reg;
            s4_q_reg   <= s4_q_next;
            s4_h_reg   <= s4_h_next;
            s4_sod_reg <= s3_sod_reg;
            s4_neg_reg <= s3_neg_reg;
            s4_oor_reg <= s3_oor_reg;
        end
        if (rdy[5])
        begin
            s5_b_reg    <= s5_b_next;
            s5_remh_reg <= s5_remh_next;
            s5_h_reg    <= s4_h_reg;
            s5_oor_reg  <= s4_oor_reg;
        end
        if (rdy[6])
        begin
            s6_n4_reg   <= s6_n4_next;
            s6_b_reg    <= s5_b_reg;
            s6_remh_reg <= s5_remh_reg;
            s6_h_reg    <= s5_h_reg;
            s6_m_reg    <= s6_m_next;
            s6_oor_reg  <= s5_oor_reg;
        end
        if (rdy[7])
        begin
            s7_c_reg   <= s7_c_next;
            s7_b_reg   <= s6_b_reg[8:0];
            s7_h_reg   <= s6_h_reg;
            s7_m_reg   <= s6_m_reg;
            s7_s_reg   <= s7_s_next;
            s7_oor_reg <= s6_oor_reg;
        end
        if (rdy[8])
        begin
            s8_x_reg   <= s8_x_next;
            s8_c_reg   <= s7_c_reg;
            s8_h_reg   <= s7_h_reg;
            s8_m_reg   <= s7_m_reg;
            s8_s_reg   <= s7_s_reg;
            s8_oor_reg <= s7_oor_reg;
        end
        if (rdy[9])
        begin
            s9_e_reg   <= s9_e_next;
            s9_x_reg   <= s8_x_reg;
            s9_c_reg   <= s8_c_reg;
            s9_h_reg   <= s8_h_reg;
            s9_m_reg   <= s8_m_reg;
            s9_s_reg   <= s8_s_reg;
            s9_oor_reg <= s8_oor_reg;
        end
        if (rdy[10])
        begin
            o_year_reg  <= o_year_next;
            o_month_reg <= o_month_next;
            o_day_reg   <= o_day_next;
            o_hour_reg  <= o_hour_next;
            o_min_reg   <= o_min_next;
            o_sec_reg   <= o_sec_next;
            o_oor_reg   <= s9_oor_reg;
        end
    end

    assign m_tdata = {{(OUT_TDATA_W - FIELDS_W){1'b0}}, o_sec_reg, o_min_reg, o_hour_reg,
                      o_day_reg, o_month_reg, o_year_reg};
    assign m_tuser = o_oor_reg;

endmodule

// ===== rtl/core/u2c_checker.sv =====
module u2c_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [u2c_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                             m_tuser
);
    import u2c_pkg::*;

    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;

    assign month  = m_tdata[MONTH_LSB +: MONTH_W];
    assign day    = m_tdata[DAY_LSB +: DAY_W];
    assign hour   = m_tdata[HOUR_LSB +: HOUR_W];
    assign minute = m_tdata[MIN_LSB +: MIN_W];
    assign second = m_tdata[SEC_LSB +: SEC_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("out-of-range item carries nonzero fields");

    a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1
            && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
        else $error("calendar field outside its range");

    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage empty");

endmodule

bind unix_time_to_calendar u2c_checker u_chk (.*);
